### rtl/gcdfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph connectivity package
// Shared widths, request and register codes, sequencer states and the
// command and status groups that pass between the sequencer and the frontier.
// ----------------------------------------------------------------------------
package gcdfs_pkg;

    // Largest number of vertices the adjacency matrix holds.
    localparam int MAX_VERTICES = 64;

    // Field widths of the request and configuration words.
    localparam int REQ_TYPE_W  = 2;
    localparam int VERTEX_W    = 6;
    localparam int START_W     = 7;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // Request codes; the fourth code is unused and answers with zeros.
    localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTED_MODE = 1'd1;

    // Reset value of the vertex count register.
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDIT_RD,
        ST_EDIT_WR,
        ST_SEARCH_INIT,
        ST_SEARCH_PICK,
        ST_SEARCH_MERGE,
        ST_RESPOND
    } gcdfs_state_t;

    // Commands from the sequencer to the frontier unit.
    typedef struct packed {
        logic init;
        logic pop;
        logic merge;
    } gcdfs_frontier_cmd_t;

    // Status from the frontier unit back to the sequencer.
    typedef struct packed {
        logic empty;
        logic all_reached;
    } gcdfs_frontier_status_t;

endpackage

### rtl/gcdfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph connectivity channels
// Request and response channels with a valid/ready handshake; a word moves
// at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface gcdfs_req_if;
    logic                                valid;
    logic                                ready;
    logic [gcdfs_pkg::REQ_TYPE_W-1:0]    req_type;
    logic [gcdfs_pkg::VERTEX_W-1:0]      from_vertex;
    logic [gcdfs_pkg::VERTEX_W-1:0]      to_vertex;
    logic [gcdfs_pkg::START_W-1:0]       start_vertex;

    modport source (output valid, req_type, from_vertex, to_vertex, start_vertex,
                    input ready);
    modport sink   (input valid, req_type, from_vertex, to_vertex, start_vertex,
                    output ready);
endinterface

interface gcdfs_rsp_if;
    logic valid;
    logic ready;
    logic connected;
    logic range_error;

    modport source (output valid, connected, range_error, input ready);
    modport sink   (input valid, connected, range_error, output ready);
endinterface

### rtl/gcdfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcdfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gcdfs_row_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency row store
// Holds one bit row per vertex in a RAM. A valid bit per row, cleared at
// reset, makes a row that was never written read as all zeros.
// ----------------------------------------------------------------------------
module gcdfs_row_store #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [MAX_VERTICES-1:0]         wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic [MAX_VERTICES-1:0]         rd_data
);

    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] row_valid_next;
    logic                    rd_valid_reg;
    logic                    rd_valid_next;
    logic [MAX_VERTICES-1:0] ram_rdata;

    gcdfs_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Mark rows as written and track the validity of the row being read.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        rd_valid_next  = rd_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
        if (rd_en)
        begin
            rd_valid_next = row_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? ram_rdata : '0;

endmodule

### rtl/gcdfs_frontier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search frontier unit
// Holds the pending and visited vertex sets of a depth-first search, picks
// the lowest pending vertex and merges an adjacency row into the frontier.
// ----------------------------------------------------------------------------
module gcdfs_frontier #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  gcdfs_pkg::gcdfs_frontier_cmd_t           cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]          start_idx,
    input  logic [MAX_VERTICES-1:0]                  row_data,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]        active_n,
    output logic [$clog2(MAX_VERTICES)-1:0]          pick_idx,
    output gcdfs_pkg::gcdfs_frontier_status_t        status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] pending_reg;
    logic [MAX_VERTICES-1:0] pending_next;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] visited_next;
    logic [MAX_VERTICES-1:0] active_mask;
    logic [MAX_VERTICES-1:0] pick_onehot;
    logic [MAX_VERTICES-1:0] start_onehot;
    logic [AW-1:0]           pick_code;

    // Vertices in use: every index below the active count.
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            active_mask[i]  = (NW'(i) < active_n);
            start_onehot[i] = (start_idx == AW'(i));
        end
    end

    // Isolate the lowest pending vertex and encode its index.
    always_comb
    begin
        pick_onehot = pending_reg & (~pending_reg + 1'b1);
        pick_code   = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            pick_code = pick_code | (pick_onehot[i] ? AW'(i) : '0);
        end
    end

    assign pick_idx           = pick_code;
    assign status.empty       = (pending_reg == '0);
    assign status.all_reached = ((visited_reg & active_mask) == active_mask);

    // Frontier update: start, move the picked vertex to visited, or merge a row.
    always_comb
    begin
        pending_next = pending_reg;
        visited_next = visited_reg;
        priority if (cmd.init)
        begin
            pending_next = start_onehot;
            visited_next = '0;
        end
        else if (cmd.pop)
        begin
            pending_next = pending_reg & ~pick_onehot;
            visited_next = visited_reg | pick_onehot;
        end
        else if (cmd.merge)
        begin
            pending_next = pending_reg | (row_data & ~visited_reg & active_mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            visited_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            visited_reg <= visited_next;
        end
    end

    // The two sets never share a vertex.
    a_sets_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & visited_reg) == '0)
        else $error("pending and visited sets overlap");

    // A picked vertex has not been visited yet.
    a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (!visited_reg[pick_idx] && pending_reg[pick_idx]))
        else $error("picked vertex is not a fresh pending vertex");

    // A new search starts from exactly one vertex with nothing visited.
    a_init_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> ($onehot(pending_reg) && visited_reg == '0))
        else $error("search did not start from a single vertex");

endmodule

### rtl/graph_connectivity_dfs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph connectivity by depth-first search
// Keeps an adjacency bit matrix and answers edge insert, edge remove and
// connectivity query requests, one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as words on the req channel and each produces exactly one
//   word on the rsp channel (connected, range_error). The cfg port writes
//   vertex_count (index 0) and directed_mode (index 1); write it only while
//   no request is in flight.
//   An insert or remove reads and writes back each row touched: one row in
//   directed mode, two in undirected mode. A query runs a pick and row-merge
//   loop over the read port of the row RAM, one pass per vertex reached.
//   Out-of-range requests go straight to the response.
//   req.ready is high only while the sequencer is idle. A result waits in the
//   output register until taken; the next request is accepted meanwhile, and
//   its own result is held back until the register is free.
//   Reset clears the graph (per-row valid bits, no clearing pass), sets the
//   vertex count to 64 and selects undirected mode.
// ----------------------------------------------------------------------------
module graph_connectivity_dfs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gcdfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gcdfs_pkg::CFG_DATA_W-1:0]    cfg_data,
    gcdfs_req_if.sink                           req,
    gcdfs_rsp_if.source                         rsp
);

    localparam int MAX_VERTICES = gcdfs_pkg::MAX_VERTICES;
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int NW0 = $clog2(MAX_VERTICES + 1);
    localparam int NW  = (NW0 > gcdfs_pkg::COUNT_W) ? NW0 : gcdfs_pkg::COUNT_W;
    localparam int FNW = NW0;

    gcdfs_pkg::gcdfs_state_t state_reg;
    gcdfs_pkg::gcdfs_state_t state_next;

    logic [gcdfs_pkg::COUNT_W-1:0] vertex_count_reg;
    logic                          directed_mode_reg;

    logic [AW-1:0] edit_row_reg;
    logic [AW-1:0] edit_row_next;
    logic [AW-1:0] edit_col_reg;
    logic [AW-1:0] edit_col_next;
    logic          op_insert_reg;
    logic          op_insert_next;
    logic          second_reg;
    logic          second_next;
    logic [AW-1:0] start_idx_reg;
    logic [AW-1:0] start_idx_next;
    logic          res_conn_reg;
    logic          res_conn_next;
    logic          res_err_reg;
    logic          res_err_next;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic rsp_conn_reg;
    logic rsp_conn_next;
    logic rsp_err_reg;
    logic rsp_err_next;

    logic [NW-1:0]           active_n;
    logic                    from_ok;
    logic                    to_ok;
    logic                    start_ok;
    logic                    store_wr;
    logic                    store_rd;
    logic [AW-1:0]           store_rd_addr;
    logic [MAX_VERTICES-1:0] store_wr_data;
    logic [MAX_VERTICES-1:0] store_rd_data;
    logic [MAX_VERTICES-1:0] col_onehot;
    logic [AW-1:0]           pick_idx;

    gcdfs_pkg::gcdfs_frontier_cmd_t    fcmd;
    gcdfs_pkg::gcdfs_frontier_status_t fstatus;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= gcdfs_pkg::VERTEX_COUNT_RESET;
            directed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcdfs_pkg::CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data;
                gcdfs_pkg::CFG_DIRECTED_MODE: directed_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Vertex count in use, capped at the matrix size, and the range checks.
    always_comb
    begin
        if (NW'(vertex_count_reg) > NW'(MAX_VERTICES))
        begin
            active_n = NW'(MAX_VERTICES);
        end
        else
        begin
            active_n = NW'(vertex_count_reg);
        end
    end

    assign from_ok  = (NW'(req.from_vertex) < active_n);
    assign to_ok    = (NW'(req.to_vertex) < active_n);
    assign start_ok = (req.start_vertex != '0) && (NW'(req.start_vertex) <= active_n);

    // One-hot column of the edge being edited, and the edited row.
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            col_onehot[i] = (edit_col_reg == AW'(i));
        end
    end

    assign store_wr_data = op_insert_reg ? (store_rd_data | col_onehot)
                                         : (store_rd_data & ~col_onehot);

    gcdfs_row_store #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (store_wr),
        .wr_addr (edit_row_reg),
        .wr_data (store_wr_data),
        .rd_en   (store_rd),
        .rd_addr (store_rd_addr),
        .rd_data (store_rd_data)
    );

    gcdfs_frontier #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_frontier (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fcmd),
        .start_idx (start_idx_reg),
        .row_data  (store_rd_data),
        .active_n  (FNW'(active_n)),
        .pick_idx  (pick_idx),
        .status    (fstatus)
    );

    // Sequencer: next state, datapath control and result words.
    always_comb
    begin
        state_next     = state_reg;
        edit_row_next  = edit_row_reg;
        edit_col_next  = edit_col_reg;
        op_insert_next = op_insert_reg;
        second_next    = second_reg;
        start_idx_next = start_idx_reg;
        res_conn_next  = res_conn_reg;
        res_err_next   = res_err_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_conn_next  = rsp_conn_reg;
        rsp_err_next   = rsp_err_reg;
        req.ready      = 1'b0;
        store_wr       = 1'b0;
        store_rd       = 1'b0;
        store_rd_addr  = edit_row_reg;
        fcmd           = '0;

        unique case (state_reg)
            gcdfs_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_insert_next = (req.req_type == gcdfs_pkg::REQ_INSERT);
                    edit_row_next  = AW'(req.from_vertex);
                    edit_col_next  = AW'(req.to_vertex);
                    second_next    = 1'b0;
                    start_idx_next = AW'(NW'(req.start_vertex) - NW'(1));
                    res_conn_next  = 1'b0;
                    res_err_next   = 1'b0;
                    priority if (req.req_type == gcdfs_pkg::REQ_INSERT ||
                                 req.req_type == gcdfs_pkg::REQ_REMOVE)
                    begin
                        if (from_ok && to_ok)
                        begin
                            state_next = gcdfs_pkg::ST_EDIT_RD;
                        end
                        else
                        begin
                            res_err_next = 1'b1;
                            state_next   = gcdfs_pkg::ST_RESPOND;
                        end
                    end
                    else if (req.req_type == gcdfs_pkg::REQ_QUERY)
                    begin
                        if (start_ok)
                        begin
                            state_next = gcdfs_pkg::ST_SEARCH_INIT;
                        end
                        else
                        begin
                            res_err_next = 1'b1;
                            state_next   = gcdfs_pkg::ST_RESPOND;
                        end
                    end
                    else
                    begin
                        state_next = gcdfs_pkg::ST_RESPOND;
                    end
                end
            end

            gcdfs_pkg::ST_EDIT_RD:
            begin
                store_rd   = 1'b1;
                state_next = gcdfs_pkg::ST_EDIT_WR;
            end

            gcdfs_pkg::ST_EDIT_WR:
            begin
                store_wr = 1'b1;
                // In undirected mode the mirrored bit is edited in a second pass.
                if (!directed_mode_reg && !second_reg)
                begin
                    second_next   = 1'b1;
                    edit_row_next = edit_col_reg;
                    edit_col_next = edit_row_reg;
                    state_next    = gcdfs_pkg::ST_EDIT_RD;
                end
                else
                begin
                    state_next = gcdfs_pkg::ST_RESPOND;
                end
            end

            gcdfs_pkg::ST_SEARCH_INIT:
            begin
                fcmd.init  = 1'b1;
                state_next = gcdfs_pkg::ST_SEARCH_PICK;
            end

            gcdfs_pkg::ST_SEARCH_PICK:
            begin
                if (fstatus.empty)
                begin
                    res_conn_next = fstatus.all_reached;
                    state_next    = gcdfs_pkg::ST_RESPOND;
                end
                else
                begin
                    fcmd.pop      = 1'b1;
                    store_rd      = 1'b1;
                    store_rd_addr = pick_idx;
                    state_next    = gcdfs_pkg::ST_SEARCH_MERGE;
                end
            end

            gcdfs_pkg::ST_SEARCH_MERGE:
            begin
                fcmd.merge = 1'b1;
                state_next = gcdfs_pkg::ST_SEARCH_PICK;
            end

            gcdfs_pkg::ST_RESPOND:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_conn_next  = res_conn_reg;
                    rsp_err_next   = res_err_reg;
                    state_next     = gcdfs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gcdfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcdfs_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers of the item in work and of the output word.
    always_ff @(posedge clk)
    begin
        edit_row_reg  <= edit_row_next;
        edit_col_reg  <= edit_col_next;
        op_insert_reg <= op_insert_next;
        second_reg    <= second_next;
        start_idx_reg <= start_idx_next;
        res_conn_reg  <= res_conn_next;
        res_err_reg   <= res_err_next;
        rsp_conn_reg  <= rsp_conn_next;
        rsp_err_reg   <= rsp_err_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.connected   = rsp_conn_reg;
    assign rsp.range_error = rsp_err_reg;

    // A row is written back only right after it was read.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr |-> $past(store_rd))
        else $error("row written without a preceding read");

    // An edit with a vertex out of range goes straight to the response.
    a_edit_error_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready &&
         (req.req_type == gcdfs_pkg::REQ_INSERT || req.req_type == gcdfs_pkg::REQ_REMOVE) &&
         !(from_ok && to_ok))
        |=> (state_reg == gcdfs_pkg::ST_RESPOND && res_err_reg))
        else $error("out-of-range edit was not rejected");

    // A failed request never reports connectivity.
    a_error_not_connected: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gcdfs_pkg::ST_RESPOND && res_err_reg) |-> !res_conn_reg)
        else $error("range error together with connected");

    // A result word is loaded only when the output register is free or drains.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.connected) &&
                                       $stable(rsp.range_error)))
        else $error("waiting result word was overwritten");

endmodule

### tb/sv/tb_graph_connectivity_dfs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph connectivity block testbench
// Drives edge insert, edge remove, connectivity query and unused-code words into the block.
// Every accepted word is run through a local graph model, and each response
// word is checked against it. A directed section comes first, then random
// phases under several vertex counts, both modes and varied flow control.
// ----------------------------------------------------------------------------
module tb_graph_connectivity_dfs;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_V          = gcdfs_pkg::MAX_VERTICES;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 2 * MAX_V + 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 230;
    localparam int NUM_PHASES     = 8;

    // The fourth request code, which the block must ignore.
    localparam logic [gcdfs_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

    // Flow control styles of the random phases.
    localparam int FLOW_FREE     = 0;
    localparam int FLOW_SEND_GAP = 1;
    localparam int FLOW_RECV_GAP = 2;
    localparam int FLOW_BOTH_GAP = 3;

    typedef struct packed {
        logic [gcdfs_pkg::REQ_TYPE_W-1:0] req_type;
        logic [gcdfs_pkg::VERTEX_W-1:0]   from_vertex;
        logic [gcdfs_pkg::VERTEX_W-1:0]   to_vertex;
        logic [gcdfs_pkg::START_W-1:0]    start_vertex;
    } request_t;

    typedef struct packed {
        logic connected;
        logic range_error;
    } answer_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [gcdfs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gcdfs_pkg::CFG_DATA_W-1:0]  cfg_data;

    gcdfs_req_if req_ch ();
    gcdfs_rsp_if rsp_ch ();

    graph_connectivity_dfs u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Local copy of the graph and of the two registers.
    logic [MAX_V-1:0]              graph_rows [MAX_V];
    logic [gcdfs_pkg::COUNT_W-1:0] vertex_limit;
    logic                          directed;

    request_t request_backlog [$];
    answer_t  expected_answers [$];
    request_t offered_word;

    int unsigned words_offered   = 0;
    int unsigned words_accepted  = 0;
    int unsigned answers_checked = 0;
    int unsigned seen_connected  = 0;
    int unsigned seen_range_err  = 0;
    int unsigned fail_count      = 0;
    int unsigned quiet_cycles    = 0;

    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    event hold_go;

    int phase_count [NUM_PHASES] = '{64, 8, 2, 100, 5, 16, 1, 33};
    int phase_dir   [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
    int phase_flow  [NUM_PHASES] = '{FLOW_FREE, FLOW_SEND_GAP, FLOW_RECV_GAP, FLOW_BOTH_GAP,
                                     FLOW_FREE, FLOW_SEND_GAP, FLOW_RECV_GAP, FLOW_BOTH_GAP};

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Works out the answer to one request and applies any edge change.
    function automatic answer_t predict_answer(request_t r);
        int unsigned n;
        logic [MAX_V-1:0] in_use;
        logic [MAX_V-1:0] seen;
        logic [MAX_V-1:0] frontier;
        int v;
        answer_t a;
        n = (vertex_limit > MAX_V) ? MAX_V : vertex_limit;
        in_use = (n >= MAX_V) ? '1 : ((64'd1 << n) - 64'd1);
        a = '0;
        unique case (r.req_type)
            gcdfs_pkg::REQ_INSERT, gcdfs_pkg::REQ_REMOVE:
            begin
                if (r.from_vertex >= n || r.to_vertex >= n)
                begin
                    a.range_error = 1'b1;
                end
                else
                begin
                    graph_rows[r.from_vertex][r.to_vertex] =
                        (r.req_type == gcdfs_pkg::REQ_INSERT);
                    if (!directed)
                    begin
                        graph_rows[r.to_vertex][r.from_vertex] =
                            (r.req_type == gcdfs_pkg::REQ_INSERT);
                    end
                end
            end
            gcdfs_pkg::REQ_QUERY:
            begin
                if (r.start_vertex == 0 || r.start_vertex > n)
                begin
                    a.range_error = 1'b1;
                end
                else
                begin
                    // Expand the lowest pending vertex until nothing is left.
                    seen = '0;
                    frontier = '0;
                    frontier[r.start_vertex - 1] = 1'b1;
                    while (frontier != '0)
                    begin
                        for (v = 0; v < MAX_V; v++)
                        begin
                            if (frontier[v])
                            begin
                                break;
                            end
                        end
                        frontier[v] = 1'b0;
                        seen[v] = 1'b1;
                        frontier = frontier | (graph_rows[v] & ~seen & in_use);
                    end
                    a.connected = ((seen & in_use) == in_use);
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    function automatic void queue_request(logic [gcdfs_pkg::REQ_TYPE_W-1:0] kind, int src,
                                          int dst, int start);
        request_t r;
        r.req_type     = kind;
        r.from_vertex  = src[gcdfs_pkg::VERTEX_W-1:0];
        r.to_vertex    = dst[gcdfs_pkg::VERTEX_W-1:0];
        r.start_vertex = start[gcdfs_pkg::START_W-1:0];
        request_backlog.push_back(r);
    endfunction

    // A single random word: mostly well-formed edits and queries, some noise.
    function automatic void queue_random(int n);
        int sel;
        int hi;
        hi = (n > 0) ? n - 1 : 0;
        sel = $urandom_range(0, 99);
        if (sel < 45 && n > 0)
        begin
            queue_request(gcdfs_pkg::REQ_INSERT, $urandom_range(0, hi),
                          $urandom_range(0, hi), 1);
        end
        else if (sel < 65 && n > 0)
        begin
            queue_request(gcdfs_pkg::REQ_REMOVE, $urandom_range(0, hi),
                          $urandom_range(0, hi), 1);
        end
        else if (sel < 88 && n > 0)
        begin
            queue_request(gcdfs_pkg::REQ_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(1, n));
        end
        else if (sel < 93)
        begin
            queue_request(REQ_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 127));
        end
        else
        begin
            queue_request(gcdfs_pkg::REQ_TYPE_W'($urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63), $urandom_range(0, 127));
        end
    endfunction

    // Links every vertex in use into a random chain, queries from its head and its tail,
    // breaks one link and queries from the head again. Returns the number of words queued.
    function automatic int queue_chain(int n);
        int perm [MAX_V];
        int i;
        int j;
        int t;
        int cut;
        for (i = 0; i < n; i++)
        begin
            perm[i] = i;
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i + 1 < n; i++)
        begin
            queue_request(gcdfs_pkg::REQ_INSERT, perm[i], perm[i + 1], 1);
        end
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, perm[0] + 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, perm[n - 1] + 1);
        cut = $urandom_range(0, n - 2);
        queue_request(gcdfs_pkg::REQ_REMOVE, perm[cut], perm[cut + 1], 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, perm[0] + 1);
        return n + 3;
    endfunction

    task automatic write_register(logic [gcdfs_pkg::CFG_INDEX_W-1:0] index, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value[gcdfs_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (index == gcdfs_pkg::CFG_VERTEX_COUNT)
        begin
            vertex_limit = value[gcdfs_pkg::COUNT_W-1:0];
        end
        else
        begin
            directed = value[0];
        end
    endtask

    // Waits until every queued word is taken and every answer has come back.
    task automatic wait_drained(int extra);
        while (request_backlog.size() != 0 || words_accepted != words_offered ||
               expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    // Request acceptance: each word taken is predicted at once.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expected_answers.push_back(predict_answer(offered_word));
            words_accepted++;
        end
    end

    // Request driver: offers the next backlog word once the last one is taken.
    always @(negedge clk)
    begin
        if (rst_n && words_accepted == words_offered)
        begin
            if (request_backlog.size() != 0 && $urandom_range(1, 100) > send_gap_pct)
            begin
                offered_word = request_backlog.pop_front();
                words_offered++;
                req_ch.valid        <= 1'b1;
                req_ch.req_type     <= offered_word.req_type;
                req_ch.from_vertex  <= offered_word.from_vertex;
                req_ch.to_vertex    <= offered_word.to_vertex;
                req_ch.start_vertex <= offered_word.start_vertex;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response ready, with random stalls and the long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp_ch.ready <= !rx_hold && ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always
    begin
        @(hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Response monitor: compares each word with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answers_checked++;
            if (rsp_ch.connected)
            begin
                seen_connected++;
            end
            if (rsp_ch.range_error)
            begin
                seen_range_err++;
            end
            if (expected_answers.size() == 0)
            begin
                report_mismatch("response word with no request outstanding");
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp_ch.connected !== want.connected)
                begin
                    report_mismatch($sformatf("answer %0d: connected %b, expected %b",
                                              answers_checked, rsp_ch.connected,
                                              want.connected));
                end
                if (rsp_ch.range_error !== want.range_error)
                begin
                    report_mismatch($sformatf("answer %0d: range_error %b, expected %b",
                                              answers_checked, rsp_ch.range_error,
                                              want.range_error));
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int p;
        int n;
        int queued;
        int flow;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = gcdfs_pkg::CFG_VERTEX_COUNT;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = gcdfs_pkg::REQ_INSERT;
        req_ch.from_vertex  = '0;
        req_ch.to_vertex    = '0;
        req_ch.start_vertex = '0;
        rsp_ch.ready        = 1'b0;
        vertex_limit        = gcdfs_pkg::VERTEX_COUNT_RESET;
        directed            = 1'b0;
        for (p = 0; p < MAX_V; p++)
        begin
            graph_rows[p] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed checks at reset settings: extremes, duplicates, absent
        // removal, self loop, out-of-range starts and the unused code.
        queue_request(gcdfs_pkg::REQ_INSERT, 0, 63, 1);
        queue_request(gcdfs_pkg::REQ_INSERT, 63, 0, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 63, 63, 64);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 0);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 127);
        queue_request(gcdfs_pkg::REQ_REMOVE, 5, 6, 1);
        queue_request(gcdfs_pkg::REQ_INSERT, 7, 7, 1);
        queue_request(REQ_UNUSED, 63, 63, 127);
        wait_drained(SETTLE_CYCLES);

        // A shrunk count keeps the long edge stored but out of the search.
        write_register(gcdfs_pkg::CFG_VERTEX_COUNT, 3);
        queue_request(gcdfs_pkg::REQ_INSERT, 0, 1, 1);
        queue_request(gcdfs_pkg::REQ_INSERT, 1, 2, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 3);
        queue_request(gcdfs_pkg::REQ_INSERT, 0, 3, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 4);
        queue_request(gcdfs_pkg::REQ_INSERT, 2, 2, 1);
        wait_drained(SETTLE_CYCLES);

        // Mode change keeps both directions; a directed removal clears one.
        write_register(gcdfs_pkg::CFG_DIRECTED_MODE, 1);
        queue_request(gcdfs_pkg::REQ_REMOVE, 0, 1, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 2);
        wait_drained(SETTLE_CYCLES);

        // No vertex in use: everything is out of range.
        write_register(gcdfs_pkg::CFG_VERTEX_COUNT, 0);
        queue_request(gcdfs_pkg::REQ_INSERT, 0, 0, 1);
        queue_request(gcdfs_pkg::REQ_REMOVE, 0, 0, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 1);
        wait_drained(SETTLE_CYCLES);

        // A count above the maximum acts as the maximum.
        write_register(gcdfs_pkg::CFG_VERTEX_COUNT, 127);
        queue_request(gcdfs_pkg::REQ_INSERT, 63, 62, 1);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 64);
        queue_request(gcdfs_pkg::REQ_QUERY, 0, 0, 65);
        wait_drained(SETTLE_CYCLES);

        // Random phases, each under its own settings and flow control.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_register(gcdfs_pkg::CFG_VERTEX_COUNT, phase_count[p]);
            write_register(gcdfs_pkg::CFG_DIRECTED_MODE, phase_dir[p]);
            flow = phase_flow[p];
            send_gap_pct   = (flow == FLOW_SEND_GAP) ? 83 : (flow == FLOW_BOTH_GAP) ? 34 : 0;
            recv_stall_pct = (flow == FLOW_RECV_GAP) ? 83 : (flow == FLOW_BOTH_GAP) ? 34 : 0;
            n = (phase_count[p] > MAX_V) ? MAX_V : phase_count[p];
            queued = 0;
            while (queued < PHASE_WORDS)
            begin
                if (n >= 2 && $urandom_range(0, 39) == 0)
                begin
                    queued += queue_chain(n);
                end
                else
                begin
                    queue_random(n);
                    queued++;
                end
            end
            // Back-pressure: hold responses off while requests keep coming.
            if (p == 0)
            begin
                -> hold_go;
            end
            wait_drained(SETTLE_CYCLES);
        end

        wait_drained(END_CYCLES);
        if (expected_answers.size() != 0)
        begin
            report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));
        end
        $display("Covered %0d requests over %0d random phases and the directed section;",
                 words_accepted, NUM_PHASES);
        $display("%0d answers checked, %0d connected, %0d range errors, %0d mismatches.",
                 answers_checked, seen_connected, seen_range_err, fail_count);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
